### sv/mbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Masked byte pattern scanner package
// Shared constants, register codes and the structs passed to the window cells.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES = 8;
  localparam int PADDR_W           = 5;
  localparam int PDATA_W           = 64;
  localparam int ADDR_W            = 32;

  typedef enum logic [1:0] {
    REG_BASE_ADDRESS   = 2'd0,
    REG_PATTERN_VALUE  = 2'd1,
    REG_NIBBLE_CARE    = 2'd2,
    REG_PATTERN_LENGTH = 2'd3
  } reg_idx_t;

  // Per-cell compare setup derived from the pattern registers.
  typedef struct packed {
    logic       active;
    logic [7:0] want;
    logic [7:0] mask;
  } cell_cfg_t;

  // Window control shared by every cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage
`default_nettype wire

### sv/mbps_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner stream interfaces
// Valid/ready channels for scanned bytes and for scan results.
// ----------------------------------------------------------------------------
interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        first_hit;
  logic [31:0] hit_address;
  logic        region_end;
  logic        none_found;

  modport source (output valid, output hit, output first_hit, output hit_address,
                  output region_end, output none_found, input ready);
  modport sink   (input valid, input hit, input first_hit, input hit_address,
                  input region_end, input none_found, output ready);
endinterface
`default_nettype wire

### sv/mbps_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner window cell
// Holds one byte of the sliding window and compares its incoming byte.
// ----------------------------------------------------------------------------
module mbps_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  mbps_pkg::cell_ctl_t  ctl,
  input  mbps_pkg::cell_cfg_t  cfg,
  input  wire  [7:0]           byte_in,
  output logic [7:0]           byte_out,
  output logic                 match
);

  logic [7:0] window_byte;

  // The compare sees the byte this cell will hold after the shift.
  assign match    = !cfg.active || (((byte_in ^ cfg.want) & cfg.mask) == 8'h00);
  assign byte_out = window_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_byte <= 8'h00;
    end else if (ctl.shift) begin
      window_byte <= ctl.clear ? 8'h00 : byte_in;
    end
  end

endmodule
`default_nettype wire

### sv/mbps_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner configuration registers
// APB register file and the per-cell pattern byte and nibble mask selection.
// ----------------------------------------------------------------------------
module mbps_regs #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES,
  parameter int LW                = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [mbps_pkg::PADDR_W-1:0]     paddr,
  input  wire  [mbps_pkg::PDATA_W-1:0]     pwdata,
  output logic [mbps_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  output logic [mbps_pkg::ADDR_W-1:0]      base_address,
  output logic [LW-1:0]                    eff_length,
  output mbps_pkg::cell_cfg_t              cell_cfg [MAX_PATTERN_BYTES]
);

  logic [63:0] pattern_value;
  logic [15:0] nibble_care;
  logic [3:0]  pattern_length;
  mbps_pkg::reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = mbps_pkg::reg_idx_t'(paddr[mbps_pkg::PADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address   <= '0;
      pattern_value  <= '0;
      nibble_care    <= '0;
      pattern_length <= 4'd1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        mbps_pkg::REG_BASE_ADDRESS:   base_address   <= pwdata[31:0];
        mbps_pkg::REG_PATTERN_VALUE:  pattern_value  <= pwdata;
        mbps_pkg::REG_NIBBLE_CARE:    nibble_care    <= pwdata[15:0];
        mbps_pkg::REG_PATTERN_LENGTH: pattern_length <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mbps_pkg::REG_BASE_ADDRESS:   prdata = {32'h0, base_address};
      mbps_pkg::REG_PATTERN_VALUE:  prdata = pattern_value;
      mbps_pkg::REG_NIBBLE_CARE:    prdata = {48'h0, nibble_care};
      mbps_pkg::REG_PATTERN_LENGTH: prdata = {60'h0, pattern_length};
      default:                      prdata = '0;
    endcase
  end

  // A length of zero acts as one; anything above the window depth is clamped.
  always_comb begin
    if (pattern_length == 4'd0) begin
      eff_length = LW'(1);
    end else if (pattern_length > 4'(MAX_PATTERN_BYTES)) begin
      eff_length = LW'(MAX_PATTERN_BYTES);
    end else begin
      eff_length = LW'(pattern_length);
    end
  end

  // Cell i holds the byte i positions back, which lines up with pattern
  // byte eff_length-1-i.
  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cfg
    logic [2:0] k;
    assign k                = 3'(int'(eff_length) - i - 1);
    assign cell_cfg[i].active = (LW'(i) < eff_length);
    assign cell_cfg[i].want   = pattern_value[{k, 3'b000} +: 8];
    assign cell_cfg[i].mask   = {{4{nibble_care[{k, 1'b1}]}}, {4{nibble_care[{k, 1'b0}]}}};
  end

endmodule
`default_nettype wire

### sv/masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Masked byte pattern scanner
// Streams region bytes through a row of window cells and reports wildcard
// pattern matches with their start address.
// ----------------------------------------------------------------------------
// The scanner takes one region byte per clock while scan_out.ready is high and
// returns one result item per byte, so a full-rate stream passes with no gaps;
// each result appears in the cycle after its byte is taken, held in an output
// register that lets the next byte in during the same cycle the result is
// taken. The rate is set by the row of window cells, which shift and compare
// in step. Program base_address, pattern_value, nibble_care and pattern_length
// over the APB port while no byte is in flight. A hit is reported for every
// window of eff_length bytes in the current region that matches on all cared
// nibbles; hit_address is base_address plus the offset of the window's first
// byte. A byte with last_byte set closes the region: its result carries
// region_end and, if the region had no hit, none_found, and the window and
// position count are cleared for the next region.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [mbps_pkg::PADDR_W-1:0]  paddr,
  input  wire  [mbps_pkg::PDATA_W-1:0]  pwdata,
  output logic [mbps_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  mbps_in_if.sink                       scan_in,
  mbps_out_if.source                    scan_out
);

  localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);
  localparam logic [31:0] SEEN_MAX = '1;

  logic [mbps_pkg::ADDR_W-1:0] base_address;
  logic [LW-1:0]               eff_length;
  mbps_pkg::cell_cfg_t         cell_cfg [MAX_PATTERN_BYTES];
  mbps_pkg::cell_ctl_t         cell_ctl;

  logic [7:0]                  cell_in  [MAX_PATTERN_BYTES];
  logic [7:0]                  cell_out [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] cell_match;

  logic        accept;
  logic [31:0] bytes_seen;
  logic [31:0] bytes_seen_next;
  logic        hit_seen;
  logic        hit_now;

  mbps_regs #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .LW                (LW)
  ) u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .base_address (base_address),
    .eff_length   (eff_length),
    .cell_cfg     (cell_cfg)
  );

  // A new byte enters whenever the output register is empty or being emptied.
  assign scan_in.ready = !scan_out.valid || scan_out.ready;
  assign accept        = scan_in.valid && scan_in.ready;

  assign cell_ctl.shift = accept;
  assign cell_ctl.clear = scan_in.last_byte;

  // Bytes move from cell to cell each accepted item; cell 0 takes the new byte.
  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i] = scan_in.data_byte;
    end else begin : g_link
      assign cell_in[i] = cell_out[i-1];
    end

    mbps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cell_ctl),
      .cfg      (cell_cfg[i]),
      .byte_in  (cell_in[i]),
      .byte_out (cell_out[i]),
      .match    (cell_match[i])
    );
  end

  // The position count saturates at its top value.
  assign bytes_seen_next = (bytes_seen == SEEN_MAX) ? bytes_seen : bytes_seen + 32'd1;

  // Only windows lying entirely inside the current region may hit.
  assign hit_now = (bytes_seen_next >= 32'(eff_length)) && (&cell_match);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      hit_seen       <= 1'b0;
      scan_out.valid <= 1'b0;
    end else begin
      if (accept) begin
        bytes_seen     <= scan_in.last_byte ? 32'd0 : bytes_seen_next;
        hit_seen       <= scan_in.last_byte ? 1'b0 : (hit_seen || hit_now);
        scan_out.valid <= 1'b1;
      end else if (scan_out.ready) begin
        scan_out.valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted byte.
  always_ff @(posedge clk) begin
    if (accept) begin
      scan_out.hit         <= hit_now;
      scan_out.first_hit   <= hit_now && !hit_seen;
      scan_out.hit_address <= hit_now ?
                              (base_address + bytes_seen_next - 32'(eff_length)) : 32'd0;
      scan_out.region_end  <= scan_in.last_byte;
      scan_out.none_found  <= scan_in.last_byte && !hit_seen && !hit_now;
    end
  end

endmodule
`default_nettype wire

### sv/mbps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner port checker
// Watches the scanner's ports for inconsistent results and stalls.
// ----------------------------------------------------------------------------
module mbps_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire        hit,
  input wire        first_hit,
  input wire [31:0] hit_address,
  input wire        region_end,
  input wire        none_found
);

  // A first hit is always a hit.
  a_first_is_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_hit |-> hit)
    else $error("first_hit without hit");

  // A missing hit carries neither an address nor a first mark.
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> (hit_address == 32'd0) && !first_hit)
    else $error("miss result carries hit data");

  // none_found only closes a region, and never on a byte that hit.
  a_none_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_found |-> region_end && !hit)
    else $error("none_found inconsistent");

  // An empty output register never holds back the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Every accepted item yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (scan_in.valid),
  .in_ready    (scan_in.ready),
  .out_valid   (scan_out.valid),
  .out_ready   (scan_out.ready),
  .hit         (scan_out.hit),
  .first_hit   (scan_out.first_hit),
  .hit_address (scan_out.hit_address),
  .region_end  (scan_out.region_end),
  .none_found  (scan_out.none_found)
);
`default_nettype wire
